[design/tsce_pkg.sv]
// ----------------------------------------------------------------------------
// tsce_pkg: shared types and constants
// Sizes, codes and control groups for the typed-stack complexity evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsce_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_ARITY   = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int NUM_TYPES   = 3;

  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int ARITY_W  = $clog2(MAX_ARITY + 1);
  localparam int FIELD_AW = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // every node starts its sum at one
  localparam logic [VALUE_WIDTH-1:0] START_VALUE = VALUE_WIDTH'(1);

  typedef enum logic [1:0] {
    TYPE_FLOAT   = 2'd0,
    TYPE_BOOL    = 2'd1,
    TYPE_LONG    = 2'd2,
    TYPE_DISCARD = 2'd3
  } type_code_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_RSVD      = 2'd3
  } err_code_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } stack_ctrl_t;

  function automatic logic [ARITY_W-1:0] clamp_arity(input logic [FIELD_AW-1:0] a);
    logic [ARITY_W-1:0] r;
    if (int'(a) > MAX_ARITY) begin
      r = ARITY_W'(MAX_ARITY);
    end else begin
      r = ARITY_W'(a);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/typed_stack_complexity_eval.sv]
// ----------------------------------------------------------------------------
// typed_stack_complexity_eval: complexity of a postfix program
// Pops typed child complexities, scales their sum by the node weight and
// pushes the result onto the stack of the node's output type.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one program node per word; in_tuser carries the program start
//           flag that empties all three stacks before the node is handled.
//   out_* : one word per node, the pushed value and an error code.
//   Each node walks pop, sum, multiply and deliver steps; a node found in
//   error goes straight to its deliver step. The pops run one a cycle on all
//   three stacks at once, each stack popping its own clamped arity. The next
//   node is accepted the cycle after the result is loaded into the output
//   register, so the block takes no new node while one is still being
//   handled.
//   Each stack is a chain of cells shifting one entry a cycle; only the
//   fill counts are cleared by reset, entries hold no reset value.
//   rst_n is synchronous: it empties the stacks and drops out_tvalid.
//   When the receiver stalls, the result holds in the output register; one
//   more node is taken in and waits in its deliver step until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_stack_complexity_eval (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // arity_float[2:0], arity_bool[5:3], arity_long[8:6], out_type[10:9],
  // weight[18:11], zero fill up to bit 23
  input  wire logic [tsce_pkg::IN_DATA_W-1:0]  in_tdata,
  // program_start[0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // node_value[31:0]
  output logic      [tsce_pkg::OUT_DATA_W-1:0] out_tdata,
  // stack_error[1:0]
  output logic      [1:0]                      out_tuser
);
  import tsce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_SUM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ARITY_W-1:0]     ar_r  [NUM_TYPES];
  logic [ARITY_W-1:0]     ar_nxt[NUM_TYPES];
  logic [VALUE_WIDTH-1:0] acc_r  [NUM_TYPES];
  logic [VALUE_WIDTH-1:0] acc_nxt[NUM_TYPES];
  type_code_t             out_type_r, out_type_nxt;
  logic [7:0]             weight_r, weight_nxt;
  logic [VALUE_WIDTH-1:0] sum_r, sum_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  err_code_t              err_r, err_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  err_code_t              out_err_r, out_err_nxt;

  stack_ctrl_t            sctrl [NUM_TYPES];
  logic [VALUE_WIDTH-1:0] stop  [NUM_TYPES];
  logic [CNT_W-1:0]       scount[NUM_TYPES];

  logic [ARITY_W-1:0]     in_ar [NUM_TYPES];
  logic [CNT_W-1:0]       eff_cnt[NUM_TYPES];
  type_code_t             in_otype;
  logic                   in_fire;
  logic                   under, full, all_last, out_free;

  for (genvar i = 0; i < NUM_TYPES; i++) begin : g_stack
    tsce_stack u_stack (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (sctrl[i]),
      .push_data(value_r),
      .top      (stop[i]),
      .count    (scount[i])
    );
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign in_ar[0] = clamp_arity(in_tdata[2:0]);
  assign in_ar[1] = clamp_arity(in_tdata[5:3]);
  assign in_ar[2] = clamp_arity(in_tdata[8:6]);
  assign in_otype = type_code_t'(in_tdata[10:9]);

  // checks run on the counts as left by the program start flag
  always_comb begin
    under = 1'b0;
    full  = 1'b0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      eff_cnt[i] = in_tuser ? '0 : scount[i];
      if (int'(eff_cnt[i]) < int'(in_ar[i])) begin
        under = 1'b1;
      end
      if (in_otype == type_code_t'(i) &&
          int'(eff_cnt[i]) - int'(in_ar[i]) >= STACK_DEPTH) begin
        full = 1'b1;
      end
    end
  end

  always_comb begin
    all_last = 1'b1;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (ar_r[i] > ARITY_W'(1)) begin
        all_last = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ar_nxt         = ar_r;
    acc_nxt        = acc_r;
    out_type_nxt   = out_type_r;
    weight_nxt     = weight_r;
    sum_nxt        = sum_r;
    value_nxt      = value_r;
    err_nxt        = err_r;
    out_data_nxt   = out_data_r;
    out_err_nxt    = out_err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    for (int i = 0; i < NUM_TYPES; i++) begin
      sctrl[i] = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_type_nxt = in_otype;
          weight_nxt   = in_tdata[18:11];
          for (int i = 0; i < NUM_TYPES; i++) begin
            ar_nxt[i]      = in_ar[i];
            acc_nxt[i]     = '0;
            sctrl[i].clear = in_tuser;
          end
          if (under) begin
            err_nxt   = ERR_UNDERFLOW;
            value_nxt = '0;
            state_nxt = S_DONE;
          end else if (full) begin
            err_nxt   = ERR_FULL;
            value_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            err_nxt   = ERR_NONE;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        for (int i = 0; i < NUM_TYPES; i++) begin
          if (ar_r[i] != '0) begin
            sctrl[i].pop = 1'b1;
            acc_nxt[i]   = acc_r[i] + stop[i];
            ar_nxt[i]    = ar_r[i] - ARITY_W'(1);
          end
        end
        if (all_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = START_VALUE + acc_r[0] + acc_r[1] + acc_r[2];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        value_nxt = sum_r * VALUE_WIDTH'(weight_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = OUT_DATA_W'(value_r);
          out_err_nxt    = err_r;
          for (int i = 0; i < NUM_TYPES; i++) begin
            sctrl[i].push = (err_r == ERR_NONE) && (out_type_r == type_code_t'(i));
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ar_r       <= ar_nxt;
    acc_r      <= acc_nxt;
    out_type_r <= out_type_nxt;
    weight_r   <= weight_nxt;
    sum_r      <= sum_nxt;
    value_r    <= value_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // an error word never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ERR_NONE) |-> out_tdata == '0)
    else $error("error word with nonzero value");

  // fill counts stay within the chain
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(scount[0]) <= STACK_DEPTH && int'(scount[1]) <= STACK_DEPTH &&
    int'(scount[2]) <= STACK_DEPTH)
    else $error("stack count beyond depth");

  // no pop from an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (sctrl[0].pop |-> scount[0] != '0) and (sctrl[1].pop |-> scount[1] != '0) and
    (sctrl[2].pop |-> scount[2] != '0))
    else $error("pop from empty stack");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[design/tsce_cell.sv]
// ----------------------------------------------------------------------------
// tsce_cell: one stack entry
// Holds a value; takes the upper neighbor on push, the lower one on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tsce_cell (
  input  wire logic                             clk,
  input  wire tsce_pkg::cell_ctrl_t             shift,
  input  wire logic [tsce_pkg::VALUE_WIDTH-1:0] from_above,
  input  wire logic [tsce_pkg::VALUE_WIDTH-1:0] from_below,
  output logic      [tsce_pkg::VALUE_WIDTH-1:0] value
);
  import tsce_pkg::*;

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (shift.push) begin
      value_nxt = from_above;
    end else if (shift.pop) begin
      value_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

`default_nettype wire

[design/tsce_stack.sv]
// ----------------------------------------------------------------------------
// tsce_stack: shifting stack
// A chain of cells with the top entry always in the first cell, plus a fill
// count. Push shifts the chain down, pop shifts it up.
// ----------------------------------------------------------------------------
`default_nettype none

module tsce_stack (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tsce_pkg::stack_ctrl_t            ctrl,
  input  wire logic [tsce_pkg::VALUE_WIDTH-1:0] push_data,
  output logic      [tsce_pkg::VALUE_WIDTH-1:0] top,
  output logic      [tsce_pkg::CNT_W-1:0]       count
);
  import tsce_pkg::*;

  logic [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;
  cell_ctrl_t             shift;

  assign shift = '{push: ctrl.push, pop: ctrl.pop};

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] above, below;
    if (i == 0) begin : g_head
      assign above = push_data;
    end else begin : g_mid
      assign above = cell_val[i-1];
    end
    // bottom cell keeps its own value on pop, nothing below is ever read
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = cell_val[i];
    end else begin : g_link
      assign below = cell_val[i+1];
    end
    tsce_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .from_above(above),
      .from_below(below),
      .value     (cell_val[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top   = cell_val[0];
  assign count = count_r;

endmodule

`default_nettype wire

[verif/typed_stack_complexity_eval_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// typed_stack_complexity_eval_tb: self-checking bench for the evaluator
// Streams postfix program nodes into the block and compares every result
// word against a behavioral model of the three typed stacks. The nodes are
// a short directed set, random mostly well-formed programs, fills up to full depth
// and random noise, with random idling on both sides.
// ----------------------------------------------------------------------------
module typed_stack_complexity_eval_tb;
  import tsce_pkg::*;

  typedef struct packed {
    logic       prog_start;
    logic [2:0] ar_float;
    logic [2:0] ar_bool;
    logic [2:0] ar_long;
    type_code_t res_type;
    logic [7:0] weight;
  } node_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    err_code_t              err;
  } outcome_t;

  // behavioral copy of the typed stacks plus the queue of pending result words
  class complexity_scoreboard;
    logic [VALUE_WIDTH-1:0] cells [NUM_TYPES][STACK_DEPTH];
    int unsigned depth [NUM_TYPES];
    outcome_t    want_q [$];
    int unsigned errors, nodes, n_ok, n_under, n_full, n_discard, deepest;

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void note(node_t n);
      int unsigned ar [NUM_TYPES];
      int unsigned raw [NUM_TYPES];
      int unsigned ot;
      logic [VALUE_WIDTH-1:0] acc;
      outcome_t r;
      nodes++;
      if (n.prog_start) begin
        foreach (depth[i]) depth[i] = 0;
      end
      raw[0] = n.ar_float;
      raw[1] = n.ar_bool;
      raw[2] = n.ar_long;
      foreach (ar[i]) ar[i] = (raw[i] > MAX_ARITY) ? MAX_ARITY : raw[i];
      ot = int'(n.res_type);
      r.value = '0;
      r.err = ERR_NONE;
      foreach (ar[i]) begin
        if (depth[i] < ar[i]) r.err = ERR_UNDERFLOW;
      end
      if (r.err == ERR_NONE && n.res_type != TYPE_DISCARD &&
          depth[ot] - ar[ot] >= STACK_DEPTH) begin
        r.err = ERR_FULL;
      end
      if (r.err == ERR_NONE) begin
        acc = START_VALUE;
        foreach (ar[i]) begin
          repeat (ar[i]) begin
            depth[i]--;
            acc = acc + cells[i][depth[i]];
          end
        end
        acc = acc * {{(VALUE_WIDTH-8){1'b0}}, n.weight};
        if (n.res_type != TYPE_DISCARD) begin
          cells[ot][depth[ot]] = acc;
          depth[ot]++;
          if (depth[ot] > deepest) deepest = depth[ot];
        end else begin
          n_discard++;
        end
        r.value = acc;
        n_ok++;
      end else if (r.err == ERR_UNDERFLOW) begin
        n_under++;
      end else begin
        n_full++;
      end
      want_q = {want_q, r};
    endfunction

    function void check(logic [OUT_DATA_W-1:0] value, logic [1:0] err);
      outcome_t x;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, value %h error %0d", $time, value, err);
        return;
      end
      x = want_q.pop_front();
      if (value !== x.value) begin
        errors++;
        $display("%0t: node_value expected %h actual %h", $time, x.value, value);
      end
      if (err !== x.err) begin
        errors++;
        $display("%0t: stack_error expected %0d actual %0d", $time, x.err, err);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  complexity_scoreboard sb = new;
  bit          steady = 1'b0;
  int unsigned sent = 0;

  typed_stack_complexity_eval u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // result side: check each word taken, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
    out_tready <= steady || ($urandom_range(99) >= 27);
  end

  function automatic node_t make_node(input logic start, input logic [2:0] af,
                                      input logic [2:0] ab, input logic [2:0] al,
                                      input type_code_t rt, input logic [7:0] w);
    node_t n;
    n.prog_start = start;
    n.ar_float   = af;
    n.ar_bool    = ab;
    n.ar_long    = al;
    n.res_type   = rt;
    n.weight     = w;
    return n;
  endfunction

  // mostly legal pop counts, now and then one too many or an oversized arity
  function automatic logic [2:0] pick_arity(input int unsigned avail);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3 && avail < 7) return 3'(avail + 1);
    if (roll < 8 && avail >= MAX_ARITY) return 3'($urandom_range(7, MAX_ARITY + 1));
    return 3'($urandom_range(avail < MAX_ARITY ? avail : MAX_ARITY));
  endfunction

  function automatic type_code_t pick_type();
    if ($urandom_range(99) < 5) return TYPE_DISCARD;
    return type_code_t'($urandom_range(2));
  endfunction

  task automatic send_node(input node_t n);
    while (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, n.weight, n.res_type, n.ar_long, n.ar_bool, n.ar_float};
    in_tuser  <= n.prog_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note(n);
    sent++;
  endtask

  // hold off the sender until every result word is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_program(input int len);
    node_t n;
    for (int i = 0; i < len; i++) begin
      n.prog_start = (i == 0);
      n.ar_float   = pick_arity(n.prog_start ? 0 : sb.depth[0]);
      n.ar_bool    = pick_arity(n.prog_start ? 0 : sb.depth[1]);
      n.ar_long    = pick_arity(n.prog_start ? 0 : sb.depth[2]);
      n.res_type   = pick_type();
      n.weight     = 8'($urandom_range(255));
      send_node(n);
    end
  endtask

  task automatic fill_stack(input type_code_t t);
    logic [2:0] one;
    one = 3'd1;
    while (sb.depth[int'(t)] < STACK_DEPTH) begin
      send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, t, 8'($urandom_range(255))));
    end
    // pushes onto a full stack are rejected
    repeat (2) send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, t, 8'($urandom_range(255))));
    // popping one first leaves room
    send_node(make_node(1'b0, t == TYPE_FLOAT ? one : 3'd0, t == TYPE_BOOL ? one : 3'd0,
                        t == TYPE_LONG ? one : 3'd0, t, 8'($urandom_range(255))));
    send_node(make_node(1'b0, t == TYPE_FLOAT ? 3'd4 : 3'd0, t == TYPE_BOOL ? 3'd4 : 3'd0,
                        t == TYPE_LONG ? 3'd4 : 3'd0, TYPE_DISCARD, 8'($urandom_range(255))));
  endtask

  initial begin
    node_t n;
    int unsigned fill_no;
    fill_no = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed nodes
    send_node(make_node(1'b1, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'd0));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'd255));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_BOOL, 8'd1));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_LONG, 8'd128));
    send_node(make_node(1'b0, 3'd1, 3'd1, 3'd1, TYPE_FLOAT, 8'd3));
    send_node(make_node(1'b0, 3'd0, 3'd1, 3'd0, TYPE_LONG, 8'd7));    // bool stack empty
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'hAA));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'h55));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'hFF));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_FLOAT, 8'h80));
    send_node(make_node(1'b0, 3'd7, 3'd0, 3'd0, TYPE_LONG, 8'd2));    // clamps to four pops
    send_node(make_node(1'b0, 3'd5, 3'd0, 3'd0, TYPE_LONG, 8'd9));    // clamped, still short
    send_node(make_node(1'b0, 3'd2, 3'd0, 3'd1, TYPE_DISCARD, 8'd255));
    // repeated long pops on an empty long stack, each an underflow
    repeat (6) send_node(make_node(1'b0, 3'd0, 3'd0, 3'd1, TYPE_LONG, 8'd255));
    send_node(make_node(1'b1, 3'd0, 3'd0, 3'd1, TYPE_LONG, 8'd1));    // cleared, underflow
    send_node(make_node(1'b1, 3'd0, 3'd0, 3'd0, TYPE_DISCARD, 8'd255));
    send_node(make_node(1'b0, 3'd0, 3'd0, 3'd0, TYPE_BOOL, 8'd255));
    send_node(make_node(1'b0, 3'd6, 3'd4, 3'd0, TYPE_BOOL, 8'd1));
    drain();

    while (sent < 1700) begin
      steady = (sent >= 800 && sent < 1100);
      if (fill_no < NUM_TYPES && sent >= 300 + 500 * fill_no) begin
        drain();
        fill_stack(type_code_t'(fill_no));
        fill_no++;
      end else if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(5, 1)) begin
          n.prog_start = ($urandom_range(7) == 0);
          n.ar_float   = 3'($urandom_range(7));
          n.ar_bool    = 3'($urandom_range(7));
          n.ar_long    = 3'($urandom_range(7));
          n.res_type   = type_code_t'($urandom_range(3));
          n.weight     = 8'($urandom_range(255));
          send_node(n);
        end
      end else begin
        run_program($urandom_range(40, 4));
      end
    end
    steady = 1'b0;

    drain();
    repeat (16) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;
    $display("covered %0d nodes: %0d evaluated (%0d discarded), %0d underflows,",
             sb.nodes, sb.n_ok, sb.n_discard, sb.n_under);
    $display("  %0d full-stack rejects, deepest stack %0d, %0d check errors",
             sb.n_full, sb.deepest, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
